### hw/rtl/ssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the streaming substring matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

   localparam int SYMBOL_W = 8;
   localparam int INDEX_W  = 6;
   localparam int LENGTH_W = 7;
   localparam int POS_W    = 32;

   localparam logic [SYMBOL_W-1:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [POS_W-1:0]    POS_TOP      = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_TEXT    = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   // Pattern store write port.
   typedef struct packed {
      logic                we;
      logic [INDEX_W-1:0]  addr;
      logic [SYMBOL_W-1:0] data;
   } pat_write_type;

   // Window control from the stage logic.
   typedef struct packed {
      logic                shift;
      logic                clear;
      logic [SYMBOL_W-1:0] symbol;
   } win_ctrl_type;

endpackage : ssm_pkg
`default_nettype wire

### hw/rtl/ssm_pattern_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pattern_store
// Register file holding the pattern bytes; every entry is read in parallel.
// ----------------------------------------------------------------------------
module ssm_pattern_store #(
   parameter int MAX_PATTERN = 64
) (
   input  wire logic                                      clock,
   input  wire ssm_pkg::pat_write_type                    wr,
   output logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0]  pattern
);

   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] pat_ff;
   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] pat_in;
   logic [31:0]                                   addr_wide;

   assign addr_wide = 32'(wr.addr);

   // Writes beyond the store depth are dropped.
   always_comb begin
      pat_in = pat_ff;
      if (wr.we && (addr_wide < 32'(MAX_PATTERN))) begin
         pat_in[addr_wide[AW-1:0]] = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   assign pattern = pat_ff;

endmodule : ssm_pattern_store
`default_nettype wire

### hw/rtl/ssm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_window
// Shift register of the most recent text bytes and its fill count.
// ----------------------------------------------------------------------------
module ssm_window #(
   parameter int MAX_PATTERN = 64,
   parameter int FW          = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire ssm_pkg::win_ctrl_type                     ctrl,
   output logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0]  win_next,
   output logic [FW-1:0]                                  fill_next
);

   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] window_ff;
   logic [FW-1:0]                                 fill_ff;
   logic [FW-1:0]                                 fill_in;

   // Entry 0 is the newest byte; the window as it stands after this byte.
   always_comb begin
      win_next[0] = ctrl.symbol;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         win_next[k] = window_ff[k-1];
      end
   end

   assign fill_next = (fill_ff == FW'(MAX_PATTERN)) ? fill_ff : fill_ff + FW'(1);

   always_comb begin
      fill_in = fill_ff;
      if (ctrl.clear) begin
         fill_in = '0;
      end else if (ctrl.shift) begin
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Bytes beyond the fill count are never compared, so contents need no reset.
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         window_ff <= win_next;
      end
   end

endmodule : ssm_window
`default_nettype wire

### hw/rtl/ssm_compare.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_compare
// Aligns the window to the pattern length and compares all lanes at once.
// ----------------------------------------------------------------------------
module ssm_compare #(
   parameter int MAX_PATTERN = 64,
   parameter int FW          = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] win,
   input  wire logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] pattern,
   input  wire logic [FW-1:0]                                 fill,
   input  wire logic [FW-1:0]                                 len,
   output logic                                               hit
);

   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // Lane i must see window byte len-1-i. Reversing the window turns that
   // into a left shift by MAX_PATTERN-len, done by a log-depth barrel shifter.
   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] stg [AW+1];
   logic [31:0]                                   shamt_wide;
   logic [AW-1:0]                                 shamt;
   logic [MAX_PATTERN-1:0]                        lane_ok;

   assign shamt_wide = 32'(MAX_PATTERN) - 32'(len);
   assign shamt      = shamt_wide[AW-1:0];

   genvar b, i;
   generate
      for (i = 0; i < MAX_PATTERN; i++) begin : g_rev
         assign stg[0][i] = win[MAX_PATTERN-1-i];
      end
      for (b = 0; b < AW; b++) begin : g_stage
         localparam int SH = 1 << b;
         for (i = 0; i < MAX_PATTERN; i++) begin : g_lane
            if (i + SH < MAX_PATTERN) begin : g_in
               assign stg[b+1][i] = shamt[b] ? stg[b][i+SH] : stg[b][i];
            end else begin : g_out
               assign stg[b+1][i] = shamt[b] ? '0 : stg[b][i];
            end
         end
      end
      for (i = 0; i < MAX_PATTERN; i++) begin : g_cmp
         assign lane_ok[i] = (32'(i) >= 32'(len)) || (stg[AW][i] == pattern[i]);
      end
   endgenerate

   assign hit = (len != '0) && (fill >= len) && (&lane_ok);

endmodule : ssm_compare
`default_nettype wire

### hw/rtl/streaming_substring_matcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// streaming_substring_matcher_core
// Exact substring matcher over a byte stream with a loadable pattern.
// ----------------------------------------------------------------------------
// Path: a text beat passes through the input stage register and then the result
// register before its result appears in rsp_valid.
// Throughput: one beat per cycle unless a result is blocked; the whole window
// compare for a byte lies between the input stage and result registers.
// Reset: synchronous and active high; it clears the stage and result valids,
// the window fill count, the position, the found flag and pattern_length.
// The pattern store is not cleared.
// ----------------------------------------------------------------------------
module streaming_substring_matcher_core #(
   parameter int MAX_PATTERN = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input channel.
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_action,
   input  wire logic [ssm_pkg::SYMBOL_W-1:0]   req_symbol,
   input  wire logic [ssm_pkg::INDEX_W-1:0]    req_pattern_index,
   // Result channel.
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_match,
   output logic [ssm_pkg::POS_W-1:0]           rsp_match_start,
   output logic                                rsp_any_found,
   // Configuration write channel.
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ssm_pkg::LENGTH_W-1:0]   csr_pattern_length
);

   localparam int FW = $clog2(MAX_PATTERN + 1);

   // Configuration register. Writes are always taken.
   logic [ssm_pkg::LENGTH_W-1:0] len_ff;
   logic [ssm_pkg::LENGTH_W-1:0] len_in;
   logic [FW-1:0]                eff_len;

   assign csr_ready = 1'b1;

   always_comb begin
      len_in = len_ff;
      if (csr_valid && csr_ready) begin
         len_in = csr_pattern_length;
      end
   end

   // Lengths above the window depth are clamped to it.
   assign eff_len = (32'(len_ff) > 32'(MAX_PATTERN)) ? FW'(MAX_PATTERN) : FW'(len_ff);

   // Input stage register. A beat may enter while a result waits downstream;
   // the stage only holds when it carries a result and the output is blocked.
   logic                          s1_valid_ff, s1_valid_in;
   ssm_pkg::action_type           s1_action_ff, s1_action_in;
   logic [ssm_pkg::SYMBOL_W-1:0]  s1_symbol_ff, s1_symbol_in;
   logic [ssm_pkg::INDEX_W-1:0]   s1_index_ff, s1_index_in;
   logic                          s1_is_text;
   logic                          s1_has_rsp;
   logic                          out_free;
   logic                          s1_go;
   logic                          fire;

   assign s1_is_text = (s1_action_ff == ssm_pkg::ACT_TEXT)
                       && (s1_symbol_ff != ssm_pkg::NEWLINE_BYTE);
   assign s1_has_rsp = s1_valid_ff && s1_is_text;
   assign out_free   = !rsp_valid || !rsp_stall;
   assign s1_go      = !s1_has_rsp || out_free;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign fire       = s1_valid_ff && s1_go;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_action_in = s1_action_ff;
      s1_symbol_in = s1_symbol_ff;
      s1_index_in  = s1_index_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_action_in = ssm_pkg::action_type'(req_action);
            s1_symbol_in = req_symbol;
            s1_index_in  = req_pattern_index;
         end
      end
   end

   // Per-action controls for the window, pattern store and counters.
   ssm_pkg::pat_write_type pat_wr;
   ssm_pkg::win_ctrl_type  win_ctrl;
   logic                   do_text;
   logic                   do_restart;

   always_comb begin
      do_text    = 1'b0;
      do_restart = 1'b0;
      pat_wr     = '{we: 1'b0, addr: s1_index_ff, data: s1_symbol_ff};
      if (fire) begin
         case (s1_action_ff)
            ssm_pkg::ACT_LOAD: begin
               pat_wr.we = 1'b1;
            end
            ssm_pkg::ACT_TEXT: begin
               // A newline byte is dropped and leaves everything untouched.
               do_text = s1_is_text;
            end
            ssm_pkg::ACT_RESTART: begin
               do_restart = 1'b1;
            end
            default: begin
            end
         endcase
      end
      win_ctrl = '{shift: do_text, clear: do_restart, symbol: s1_symbol_ff};
   end

   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] pattern;
   logic [MAX_PATTERN-1:0][ssm_pkg::SYMBOL_W-1:0] win_next;
   logic [FW-1:0]                                 fill_next;
   logic                                          hit;

   ssm_pattern_store #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_pattern (
      .clock   (clock),
      .wr      (pat_wr),
      .pattern (pattern)
   );

   ssm_window #(
      .MAX_PATTERN (MAX_PATTERN),
      .FW          (FW)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .win_next  (win_next),
      .fill_next (fill_next)
   );

   // The compare looks at the window as it will be after this byte.
   ssm_compare #(
      .MAX_PATTERN (MAX_PATTERN),
      .FW          (FW)
   ) u_compare (
      .win     (win_next),
      .pattern (pattern),
      .fill    (fill_next),
      .len     (eff_len),
      .hit     (hit)
   );

   // Text position of the next byte; it saturates at its top value.
   logic [ssm_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      found_ff, found_in;

   always_comb begin
      pos_in   = pos_ff;
      found_in = found_ff;
      if (do_restart) begin
         pos_in   = '0;
         found_in = 1'b0;
      end else if (do_text) begin
         if (pos_ff != ssm_pkg::POS_TOP) begin
            pos_in = pos_ff + 32'd1;
         end
         found_in = found_ff || hit;
      end
   end

   // Result register. It loads whenever a result leaves the stage, which is
   // only allowed while the register is empty or being drained.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_match_ff, rsp_match_in;
   logic [ssm_pkg::POS_W-1:0] rsp_start_ff, rsp_start_in;
   logic                      rsp_found_ff, rsp_found_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      rsp_start_in = rsp_start_ff;
      rsp_found_in = rsp_found_ff;
      if (do_text) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = hit;
         // Start of the match is computed modulo 2^32; it stops advancing once the position saturates.
         rsp_start_in = hit ? (pos_ff - 32'(eff_len) + 32'd1) : '0;
         rsp_found_in = found_ff || hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_action_ff <= s1_action_in;
      s1_symbol_ff <= s1_symbol_in;
      s1_index_ff  <= s1_index_in;
      rsp_match_ff <= rsp_match_in;
      rsp_start_ff <= rsp_start_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match       = rsp_match_ff;
   assign rsp_match_start = rsp_start_ff;
   assign rsp_any_found   = rsp_found_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A beat that reports a match must also report the sticky flag.
   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> rsp_any_found)
      else $error("match reported without the found flag");

   // A beat without a match carries a zero start position.
   a_nomatch_zero_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match) |-> (rsp_match_start == '0))
      else $error("nonzero start position on a beat without a match");

   // The input side only holds off when a result is blocked downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_has_rsp && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // A zero pattern length never produces a match.
   a_zero_len_no_match: assert property (@(posedge clock) disable iff (reset)
      (fire && do_text && (eff_len == '0)) |=> !rsp_match)
      else $error("match reported with a zero pattern length");

endmodule : streaming_substring_matcher_core
`default_nettype wire
